/* sv/gbsd_pkg.sv */
// Shared types and constants of the gap-bridged segment detector.
package gbsd_pkg;

  localparam int PROB_W   = 16;
  localparam int GAP_W    = 8;
  localparam int LEN_W    = 13;
  localparam int OUT_W    = 13;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH      = 2'd2;

  // Register values after reset.
  localparam logic [PROB_W-1:0] LEVEL_THRESHOLD_RST = 16'd32768;
  localparam logic [GAP_W-1:0]  MAX_GAP_RST         = 8'd5;
  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST      = 13'd10;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              last_frame;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] segment_start;
    logic [OUT_W-1:0] segment_end;
  } out_word_t;

endpackage

/* sv/gap_bridged_segment_detector_top.sv */
// Top level of the gap-bridged segment detector: threshold, gap bridging and output queue.
//
//   channel  | direction | handshake              | word
//   in       | input     | in_valid / in_ready    | in_word  (probability, last_frame)
//   out      | output    | out_valid / out_ready  | out_word (segment_start, segment_end)
//   cfg      | input     | cfg_write              | cfg_index, cfg_data
//
// One word is taken per cycle; its result, if any, is offered in the next cycle unless an
// earlier word still waits in the output register, in which case it waits in the skid register.
// A two-entry output queue (output register plus skid register) sets the rate: in_ready drops
// only while both entries hold a word that has not been taken.
// Synchronous reset clears the frame state, the queue and loads the register defaults.
module gap_bridged_segment_detector_top
  import gbsd_pkg::*;
#(
  parameter int MAX_FRAMES = 8192
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int WIDE_W  = (FRAME_W > LEN_W) ? FRAME_W : LEN_W;
  localparam int CMP_W   = WIDE_W + 2;
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(MAX_FRAMES - 1);

  // Configuration registers.
  logic [PROB_W-1:0] level_threshold;
  logic [GAP_W-1:0]  max_gap;
  logic [LEN_W-1:0]  min_length;

  // Sequence state.
  logic [FRAME_W-1:0] frame_index, frame_index_next;
  logic               segment_open, segment_open_next;
  logic [FRAME_W-1:0] open_start, open_start_next;
  logic [GAP_W-1:0]   gap_run, gap_run_next;

  // Output queue.
  logic      skid_valid;
  out_word_t skid_word;

  logic       accept;
  logic       pop;
  logic       push;
  logic       active;
  logic [CMP_W-1:0] close_diff;
  logic [CMP_W-1:0] flush_len;
  logic [CMP_W-1:0] min_length_ext;
  out_word_t  result_word;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign active         = in_word.probability >= level_threshold;
  assign min_length_ext = CMP_W'(min_length);
  // Trimmed end minus start; negative values show up with the top bit set.
  assign close_diff = CMP_W'(frame_index) - CMP_W'(gap_run) - CMP_W'(1) - CMP_W'(open_start);

  always_comb begin
    logic [CMP_W-1:0] start_ext;
    logic [CMP_W-1:0] end_ext;
    segment_open_next = segment_open;
    open_start_next   = open_start;
    gap_run_next      = gap_run;
    push              = 1'b0;
    start_ext         = CMP_W'(open_start);
    end_ext           = close_diff + CMP_W'(open_start);
    flush_len         = '0;

    if (active) begin
      if (!segment_open) begin
        segment_open_next = 1'b1;
        open_start_next   = frame_index;
      end
      gap_run_next = '0;
    end else if (segment_open) begin
      if (gap_run < max_gap) begin
        gap_run_next = gap_run + GAP_W'(1);
      end else begin
        if (!close_diff[CMP_W-1] && close_diff >= min_length_ext) begin
          push = 1'b1;
        end
        segment_open_next = 1'b0;
        gap_run_next      = '0;
      end
    end

    if (in_word.last_frame) begin
      flush_len = CMP_W'(frame_index) + CMP_W'(1) - CMP_W'(open_start_next);
      if (segment_open_next && flush_len >= min_length_ext) begin
        push      = 1'b1;
        start_ext = CMP_W'(open_start_next);
        end_ext   = CMP_W'(frame_index);
      end
      segment_open_next = 1'b0;
      open_start_next   = '0;
      gap_run_next      = '0;
      frame_index_next  = '0;
    end else if (frame_index < FRAME_LAST) begin
      frame_index_next = frame_index + FRAME_W'(1);
    end else begin
      frame_index_next = frame_index;
    end

    result_word.segment_start = start_ext[OUT_W-1:0];
    result_word.segment_end   = end_ext[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= LEVEL_THRESHOLD_RST;
      max_gap         <= MAX_GAP_RST;
      min_length      <= MIN_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEVEL_THRESHOLD: level_threshold <= cfg_data[PROB_W-1:0];
        CFG_MAX_GAP:         max_gap         <= cfg_data[GAP_W-1:0];
        CFG_MIN_LENGTH:      min_length      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index  <= '0;
      segment_open <= 1'b0;
      open_start   <= '0;
      gap_run      <= '0;
    end else if (accept) begin
      frame_index  <= frame_index_next;
      segment_open <= segment_open_next;
      open_start   <= open_start_next;
      gap_run      <= gap_run_next;
    end
  end

  // A new word goes to the output register when it is free or being drained,
  // otherwise it waits in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (accept && push) begin
      if (!out_valid || pop) begin
        out_word <= result_word;
      end else begin
        skid_word <= result_word;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a word while the output register is empty");

  a_closed_no_gap: assert property (@(posedge clk) disable iff (rst)
    !segment_open |-> gap_run == '0)
    else $error("gap count is nonzero with no open segment");

  a_start_order: assert property (@(posedge clk) disable iff (rst)
    segment_open |-> open_start <= frame_index)
    else $error("open segment starts after the current frame");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.last_frame |=> frame_index == '0 && !segment_open)
    else $error("sequence state not cleared after the last frame");

endmodule
